[hw/rtl/i2cmrs_pkg.sv]
// ----------------------------------------------------------------------------
// I2C master read sequencer package
// Shared widths, status codes and the result record.
// ----------------------------------------------------------------------------
package i2cmrs_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_ADDRESS_BYTE = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACK_TIMEOUT = 1'd1;

  localparam logic [7:0] ADDRESS_BYTE_RST = 8'hB5;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BEGIN = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BUSY      = 2'd1,
    ST_START_ERR = 2'd2,
    ST_NO_ACK    = 2'd3
  } status_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       done_res;
    status_t    status;
  } result_t;

endpackage

[hw/rtl/i2c_master_read_sequencer.sv]
// ----------------------------------------------------------------------------
// I2C master read sequencer
// Runs one I2C read, one bus phase per tick transaction.
//
//   channel | direction | tdata (low bit up)                  | side bands
//   in_     | slave     | byte_count[7:0], sda_in[8]          | tuser: operation
//   out_    | master    | scl_out, sda_out, data_byte, status | tuser: data_valid,
//           |           |                                     | done_res; tlast
//   cfg_    | write     | 0 address_byte, 1 ack_timeout       | -
//
// One transaction in, one result out, a new one taken as the last result leaves;
// the phase state machine updates in the accepting cycle and the result sits in
// one output register. A stalled result register holds in_tready low only while
// it is full and out_tready is low. Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module i2c_master_read_sequencer
  import i2cmrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,   // byte_count[7:0], sda_in[8], zero pad
  input  logic                in_tuser,   // operation
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,  // scl_out[0], sda_out[1], data_byte[9:2],
                                          // status[11:10], zero pad
  output logic [1:0]          out_tuser,  // data_valid[0], done_res[1]
  output logic                out_tlast,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  logic [7:0] addr_r;
  logic [7:0] ack_timeout_r;
  logic       accept;
  result_t    core_result;
  result_t    out_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r        <= ADDRESS_BYTE_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ADDRESS_BYTE: addr_r        <= cfg_wdata;
        CFG_ACK_TIMEOUT:  ack_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign accept = in_tvalid && in_tready;

  i2cmrs_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (accept),
    .operation    (in_tuser),
    .byte_count   (in_tdata[7:0]),
    .sda_in       (in_tdata[8]),
    .address_byte (addr_r),
    .ack_timeout  (ack_timeout_r),
    .result       (core_result)
  );

  i2cmrs_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_tvalid),
    .load_data  (core_result),
    .ready      (in_tready),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_data   (out_result)
  );

  assign out_tdata = {4'b0000, out_result.status, out_result.data_byte,
                      out_result.sda_out, out_result.scl_out};
  assign out_tuser = {out_result.done_res, out_result.data_valid};
  assign out_tlast = out_result.last_byte;

endmodule

[hw/rtl/i2cmrs_core.sv]
// ----------------------------------------------------------------------------
// I2C master read sequencer core
// Bus phase state machine; one phase step and one result per transaction.
// ----------------------------------------------------------------------------
module i2cmrs_core
  import i2cmrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       operation,
  input  logic [7:0] byte_count,
  input  logic       sda_in,
  input  logic [7:0] address_byte,
  input  logic [7:0] ack_timeout,
  output result_t    result
);

  typedef enum logic [4:0] {
    PH_IDLE         = 5'd0,
    PH_START_SAMPLE = 5'd1,
    PH_START_LOW    = 5'd2,
    PH_ADDR_SETUP   = 5'd3,
    PH_ADDR_HIGH    = 5'd4,
    PH_ADDR_HOLD    = 5'd5,
    PH_ACK_SETUP    = 5'd6,
    PH_ACK_WAIT     = 5'd7,
    PH_RD_LOW       = 5'd8,
    PH_RD_HIGH      = 5'd9,
    PH_RD_END       = 5'd10,
    PH_MACK_SETUP   = 5'd11,
    PH_MACK_HIGH    = 5'd12,
    PH_MACK_HOLD    = 5'd13,
    PH_STOP_PRE     = 5'd14,
    PH_STOP_A       = 5'd15,
    PH_STOP_B       = 5'd16,
    PH_STOP_C       = 5'd17
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [2:0] bit_index_r, bit_index_nxt;
  logic [7:0] shift_reg_r, shift_reg_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] wait_count_r, wait_count_nxt;
  status_t    end_status_r, end_status_nxt;

  always_comb begin
    phase_nxt      = phase_r;
    bit_index_nxt  = bit_index_r;
    shift_reg_nxt  = shift_reg_r;
    bytes_left_nxt = bytes_left_r;
    wait_count_nxt = wait_count_r;
    end_status_nxt = end_status_r;
    result         = '0;
    result.scl_out = 1'b1;
    result.sda_out = 1'b1;
    result.status  = ST_OK;

    unique case (phase_r)
      PH_START_SAMPLE: begin
        if (!sda_in) begin
          result.done_res = 1'b1;
          result.status   = ST_BUSY;
          phase_nxt       = PH_IDLE;
        end else begin
          result.sda_out = 1'b0;
          phase_nxt      = PH_START_LOW;
        end
      end
      PH_START_LOW: begin
        if (sda_in) begin
          result.done_res = 1'b1;
          result.status   = ST_START_ERR;
          phase_nxt       = PH_IDLE;
        end else begin
          result.scl_out = 1'b0;
          result.sda_out = 1'b0;
          shift_reg_nxt  = address_byte;
          bit_index_nxt  = 3'd7;
          phase_nxt      = PH_ADDR_SETUP;
        end
      end
      PH_ADDR_SETUP: begin
        result.sda_out = shift_reg_r[bit_index_r];
        result.scl_out = 1'b0;
        phase_nxt      = PH_ADDR_HIGH;
      end
      PH_ADDR_HIGH: begin
        result.sda_out = shift_reg_r[bit_index_r];
        phase_nxt      = PH_ADDR_HOLD;
      end
      PH_ADDR_HOLD: begin
        result.sda_out = shift_reg_r[bit_index_r];
        result.scl_out = 1'b0;
        if (bit_index_r == 3'd0) begin
          phase_nxt = PH_ACK_SETUP;
        end else begin
          bit_index_nxt = bit_index_r - 3'd1;
          phase_nxt     = PH_ADDR_SETUP;
        end
      end
      PH_ACK_SETUP: begin
        result.scl_out = 1'b0;
        wait_count_nxt = '0;
        phase_nxt      = PH_ACK_WAIT;
      end
      PH_ACK_WAIT: begin
        if (!sda_in) begin
          if (bytes_left_r == 8'd0) begin
            end_status_nxt = ST_OK;
            phase_nxt      = PH_STOP_A;
          end else begin
            bit_index_nxt = 3'd7;
            shift_reg_nxt = '0;
            phase_nxt     = PH_RD_LOW;
          end
        end else if (wait_count_r >= ack_timeout) begin
          end_status_nxt = ST_NO_ACK;
          phase_nxt      = PH_STOP_PRE;
        end else begin
          wait_count_nxt = wait_count_r + 8'd1;
        end
      end
      PH_RD_LOW: begin
        result.scl_out = 1'b0;
        phase_nxt      = PH_RD_HIGH;
      end
      PH_RD_HIGH: begin
        shift_reg_nxt = {shift_reg_r[6:0], sda_in};
        if (bit_index_r == 3'd0) begin
          result.data_valid = 1'b1;
          result.data_byte  = {shift_reg_r[6:0], sda_in};
          result.last_byte  = (bytes_left_r == 8'd1);
          bytes_left_nxt    = bytes_left_r - 8'd1;
          phase_nxt         = PH_RD_END;
        end else begin
          bit_index_nxt = bit_index_r - 3'd1;
          phase_nxt     = PH_RD_LOW;
        end
      end
      PH_RD_END: begin
        result.scl_out = 1'b0;
        phase_nxt      = PH_MACK_SETUP;
      end
      PH_MACK_SETUP: begin
        result.sda_out = (bytes_left_r == 8'd0);
        result.scl_out = 1'b0;
        phase_nxt      = PH_MACK_HIGH;
      end
      PH_MACK_HIGH: begin
        result.sda_out = (bytes_left_r == 8'd0);
        phase_nxt      = PH_MACK_HOLD;
      end
      PH_MACK_HOLD: begin
        result.sda_out = (bytes_left_r == 8'd0);
        result.scl_out = 1'b0;
        if (bytes_left_r != 8'd0) begin
          bit_index_nxt = 3'd7;
          shift_reg_nxt = '0;
          phase_nxt     = PH_RD_LOW;
        end else begin
          end_status_nxt = ST_OK;
          phase_nxt      = PH_STOP_A;
        end
      end
      PH_STOP_PRE: begin
        result.scl_out = 1'b0;
        phase_nxt      = PH_STOP_A;
      end
      PH_STOP_A: begin
        result.scl_out = 1'b0;
        result.sda_out = 1'b0;
        phase_nxt      = PH_STOP_B;
      end
      PH_STOP_B: begin
        result.sda_out = 1'b0;
        phase_nxt      = PH_STOP_C;
      end
      PH_STOP_C: begin
        result.done_res = 1'b1;
        result.status   = end_status_r;
        phase_nxt       = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (operation == OP_BEGIN) begin
          bytes_left_nxt = byte_count;
          bit_index_nxt  = '0;
          shift_reg_nxt  = '0;
          wait_count_nxt = '0;
          end_status_nxt = ST_OK;
          phase_nxt      = PH_START_SAMPLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_index_r  <= '0;
      shift_reg_r  <= '0;
      bytes_left_r <= '0;
      wait_count_r <= '0;
      end_status_r <= ST_OK;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bit_index_r  <= bit_index_nxt;
      shift_reg_r  <= shift_reg_nxt;
      bytes_left_r <= bytes_left_nxt;
      wait_count_r <= wait_count_nxt;
      end_status_r <= end_status_nxt;
    end
  end

endmodule

[hw/rtl/i2cmrs_out_reg.sv]
// ----------------------------------------------------------------------------
// I2C master read sequencer output register
// Result register with valid flag; takes a new result while the old one leaves.
// ----------------------------------------------------------------------------
module i2cmrs_out_reg
  import i2cmrs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_data,
  output logic    ready,
  input  logic    out_tready,
  output logic    out_valid,
  output result_t out_data
);

  logic    valid_r;
  result_t data_r;

  assign ready     = !valid_r || out_tready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && ready) begin
      data_r <= load_data;
    end
  end

endmodule

[tb/sv/i2c_master_read_sequencer_checker.sv]
// ----------------------------------------------------------------------------
// I2C master read sequencer checker
// Watches the tick and result channels and the register port. Keeps its own
// copy of the bus phase machine, predicts one result per accepted tick
// transaction and compares every returned result field by field, in order.
// ----------------------------------------------------------------------------
module i2c_master_read_sequencer_checker
  import i2cmrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [15:0]         in_tdata,   // byte_count[7:0], sda_in[8], zero pad
  input  logic                in_tuser,   // operation
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [15:0]         out_tdata,  // scl_out[0], sda_out[1], data_byte[9:2],
                                          // status[11:10], zero pad
  input  logic [1:0]          out_tuser,  // data_valid[0], done_res[1]
  input  logic                out_tlast,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output int                  mismatches,
  output int                  pending,
  output logic                seq_idle,
  output int                  results_seen,
  output int                  bytes_seen,
  output int                  clean_ends,
  output int                  aborted_ends
);

  typedef enum logic [4:0] {
    S_IDLE, S_BUS_CHECK, S_START, S_ADR_SETUP, S_ADR_HIGH, S_ADR_HOLD,
    S_ACK_SETUP, S_ACK_WAIT, S_RD_LOW, S_RD_HIGH, S_RD_END,
    S_MA_SETUP, S_MA_HIGH, S_MA_HOLD, S_STOP_LOW, S_STOP_A, S_STOP_B, S_STOP_C
  } bus_state_t;

  bus_state_t bus_state;
  logic [2:0] bit_pos;
  logic [7:0] shifter;
  logic [7:0] bytes_to_read;
  logic [7:0] ack_wait;
  status_t    end_code;
  logic [7:0] addr_reg;
  logic [7:0] timeout_reg;
  result_t    expected_results[$];
  result_t    want;
  result_t    got;

  function automatic result_t advance_bus(input logic op, input logic [7:0] cnt,
                                          input logic sda);
    result_t r;
    r = '0;
    r.scl_out = 1'b1;
    r.sda_out = 1'b1;
    r.status = ST_OK;
    case (bus_state)
      S_BUS_CHECK: begin
        if (!sda) begin
          r.done_res = 1'b1;
          r.status = ST_BUSY;
          bus_state = S_IDLE;
        end else begin
          r.sda_out = 1'b0;
          bus_state = S_START;
        end
      end
      S_START: begin
        if (sda) begin
          r.done_res = 1'b1;
          r.status = ST_START_ERR;
          bus_state = S_IDLE;
        end else begin
          r.scl_out = 1'b0;
          r.sda_out = 1'b0;
          shifter = addr_reg;
          bit_pos = 3'd7;
          bus_state = S_ADR_SETUP;
        end
      end
      S_ADR_SETUP, S_ADR_HIGH, S_ADR_HOLD: begin
        r.sda_out = shifter[bit_pos];
        r.scl_out = (bus_state == S_ADR_HIGH);
        if (bus_state == S_ADR_SETUP) begin
          bus_state = S_ADR_HIGH;
        end else if (bus_state == S_ADR_HIGH) begin
          bus_state = S_ADR_HOLD;
        end else if (bit_pos == 3'd0) begin
          bus_state = S_ACK_SETUP;
        end else begin
          bit_pos = bit_pos - 3'd1;
          bus_state = S_ADR_SETUP;
        end
      end
      S_ACK_SETUP: begin
        r.scl_out = 1'b0;
        ack_wait = 8'd0;
        bus_state = S_ACK_WAIT;
      end
      S_ACK_WAIT: begin
        if (!sda) begin
          if (bytes_to_read == 8'd0) begin
            end_code = ST_OK;
            bus_state = S_STOP_A;
          end else begin
            bit_pos = 3'd7;
            shifter = 8'd0;
            bus_state = S_RD_LOW;
          end
        end else if (ack_wait >= timeout_reg) begin
          end_code = ST_NO_ACK;
          bus_state = S_STOP_LOW;
        end else begin
          ack_wait = ack_wait + 8'd1;
        end
      end
      S_RD_LOW: begin
        r.scl_out = 1'b0;
        bus_state = S_RD_HIGH;
      end
      S_RD_HIGH: begin
        shifter = {shifter[6:0], sda};
        if (bit_pos == 3'd0) begin
          r.data_valid = 1'b1;
          r.data_byte = shifter;
          r.last_byte = (bytes_to_read == 8'd1);
          bytes_to_read = bytes_to_read - 8'd1;
          bus_state = S_RD_END;
        end else begin
          bit_pos = bit_pos - 3'd1;
          bus_state = S_RD_LOW;
        end
      end
      S_RD_END: begin
        r.scl_out = 1'b0;
        bus_state = S_MA_SETUP;
      end
      S_MA_SETUP, S_MA_HIGH, S_MA_HOLD: begin
        r.sda_out = (bytes_to_read == 8'd0);
        r.scl_out = (bus_state == S_MA_HIGH);
        if (bus_state == S_MA_SETUP) begin
          bus_state = S_MA_HIGH;
        end else if (bus_state == S_MA_HIGH) begin
          bus_state = S_MA_HOLD;
        end else if (bytes_to_read != 8'd0) begin
          bit_pos = 3'd7;
          shifter = 8'd0;
          bus_state = S_RD_LOW;
        end else begin
          end_code = ST_OK;
          bus_state = S_STOP_A;
        end
      end
      S_STOP_LOW: begin
        r.scl_out = 1'b0;
        bus_state = S_STOP_A;
      end
      S_STOP_A: begin
        r.scl_out = 1'b0;
        r.sda_out = 1'b0;
        bus_state = S_STOP_B;
      end
      S_STOP_B: begin
        r.sda_out = 1'b0;
        bus_state = S_STOP_C;
      end
      S_STOP_C: begin
        r.done_res = 1'b1;
        r.status = end_code;
        bus_state = S_IDLE;
      end
      default: begin
        bus_state = S_IDLE;
        if (op == OP_BEGIN) begin
          bytes_to_read = cnt;
          bit_pos = 3'd0;
          shifter = 8'd0;
          ack_wait = 8'd0;
          end_code = ST_OK;
          bus_state = S_BUS_CHECK;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      bus_state = S_IDLE;
      bit_pos = 3'd0;
      shifter = 8'd0;
      bytes_to_read = 8'd0;
      ack_wait = 8'd0;
      end_code = ST_OK;
      addr_reg = ADDRESS_BYTE_RST;
      timeout_reg = ACK_TIMEOUT_RST;
      expected_results.delete();
      mismatches <= 0;
      results_seen <= 0;
      bytes_seen <= 0;
      clean_ends <= 0;
      aborted_ends <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ADDRESS_BYTE: addr_reg = cfg_wdata;
          CFG_ACK_TIMEOUT:  timeout_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.scl_out = out_tdata[0];
        got.sda_out = out_tdata[1];
        got.data_byte = out_tdata[9:2];
        got.status = status_t'(out_tdata[11:10]);
        got.data_valid = out_tuser[0];
        got.done_res = out_tuser[1];
        got.last_byte = out_tlast;
        if (expected_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected at %0t: scl %b sda %b vld %b byte %02h last %b done %b st %0d",
                     $time, got.scl_out, got.sda_out, got.data_valid, got.data_byte,
                     got.last_byte, got.done_res, got.status);
        end else begin
          want = expected_results.pop_front();
          results_seen <= results_seen + 1;
          if (want.data_valid) bytes_seen <= bytes_seen + 1;
          if (want.done_res && want.status == ST_OK) clean_ends <= clean_ends + 1;
          if (want.done_res && want.status != ST_OK) aborted_ends <= aborted_ends + 1;
          if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
              got.data_valid !== want.data_valid || got.data_byte !== want.data_byte ||
              got.last_byte !== want.last_byte || got.done_res !== want.done_res ||
              got.status !== want.status) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
              $display("mismatch at %0t: want scl %b sda %b vld %b byte %02h last %b",
                       $time, want.scl_out, want.sda_out, want.data_valid,
                       want.data_byte, want.last_byte);
              $display("  want done %b st %0d; got scl %b sda %b vld %b byte %02h",
                       want.done_res, want.status, got.scl_out, got.sda_out,
                       got.data_valid, got.data_byte);
              $display("  got last %b done %b st %0d",
                       got.last_byte, got.done_res, got.status);
            end
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(advance_bus(in_tuser, in_tdata[7:0], in_tdata[8]));
    end
    pending <= expected_results.size();
    seq_idle <= (bus_state == S_IDLE);
  end

endmodule

[tb/sv/i2c_master_read_sequencer_test.sv]
// ----------------------------------------------------------------------------
// I2C master read sequencer testbench
// Drives tick and begin transactions shaped as slave responses: clean reads of
// various lengths, busy bus, failed start, missing acknowledge and stray
// noise, under several register settings, with random gaps and stalls on
// both channels. The checker predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module i2c_master_read_sequencer_test;
  import i2cmrs_pkg::*;

  localparam int CycleLimit = 1500000;

  typedef enum int {RUN_OK, RUN_BUSY, RUN_START_ERR, RUN_NO_ACK} run_kind_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [15:0]         in_tdata = '0;
  logic                in_tuser = OP_TICK;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [15:0]         out_tdata;
  logic [1:0]          out_tuser;
  logic                out_tlast;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = CFG_ADDRESS_BYTE;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int         mismatches;
  int         pending;
  logic       seq_idle;
  int         results_seen;
  int         bytes_seen;
  int         clean_ends;
  int         aborted_ends;

  int         cycles = 0;
  int         ready_hold = 0;
  int         ready_pick;
  int         items_sent = 0;
  bit         no_gaps = 1'b0;
  logic [7:0] cur_timeout = ACK_TIMEOUT_RST;
  int         phase_no;
  int         phase_end;
  int         choice;
  logic [7:0] count;

  always #2 clk = ~clk;

  i2c_master_read_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  i2c_master_read_sequencer_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .pending      (pending),
    .seq_idle     (seq_idle),
    .results_seen (results_seen),
    .bytes_seen   (bytes_seen),
    .clean_ends   (clean_ends),
    .aborted_ends (aborted_ends)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL i2c_master_read_sequencer");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 50) begin
        out_tready <= 1'b1;
        ready_hold <= $urandom_range(0, 20);
      end else if (ready_pick < 90) begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(5, 30);
      end
    end
  end

  task automatic push_item(input logic op, input logic [7:0] cnt, input logic sda);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 98) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {7'd0, sda, cnt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // a begin during a run acts as a tick, so sprinkle some in
  task automatic push_tick(input logic sda);
    push_item(($urandom_range(0, 15) == 0) ? OP_BEGIN : OP_TICK,
              8'($urandom_range(0, 255)), sda);
  endtask

  task automatic run_read(input run_kind_t kind, input logic [7:0] cnt, input int fill);
    int delay;
    logic [7:0] data;
    no_gaps = ($urandom_range(0, 3) == 0);
    push_item(OP_BEGIN, cnt, 1'($urandom_range(0, 1)));
    if (kind == RUN_BUSY) begin
      push_tick(1'b0);
      return;
    end
    push_tick(1'b1);
    if (kind == RUN_START_ERR) begin
      push_tick(1'b1);
      return;
    end
    push_tick(1'b0);
    repeat (25) push_tick(1'($urandom_range(0, 1)));
    if (kind == RUN_NO_ACK) begin
      repeat (int'(cur_timeout) + 1) push_tick(1'b1);
      repeat (4) push_tick(1'($urandom_range(0, 1)));
      return;
    end
    if ($urandom_range(0, 7) == 0) delay = int'(cur_timeout);
    else delay = $urandom_range(0, (cur_timeout < 8'd3) ? int'(cur_timeout) : 3);
    repeat (delay) push_tick(1'b1);
    push_tick(1'b0);
    for (int b = 0; b < int'(cnt); b++) begin
      data = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      for (int i = 7; i >= 0; i--) begin
        push_tick(1'($urandom_range(0, 1)));
        push_tick(data[i]);
      end
      repeat (4) push_tick(1'($urandom_range(0, 1)));
    end
    repeat (3) push_tick(1'($urandom_range(0, 1)));
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(5, 20))
      push_item(($urandom_range(0, 3) == 0) ? OP_BEGIN : OP_TICK,
                ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 3)),
                1'($urandom_range(0, 1)));
  endtask

  // tick with SDA low until the sequencer is idle, then let results drain
  task automatic quiesce();
    do push_item(OP_TICK, 8'($urandom_range(0, 255)), 1'b0); while (!seq_idle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_registers(input logic [7:0] addr, input logic [7:0] tmo);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ADDRESS_BYTE;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_index <= CFG_ACK_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_timeout = tmo;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_item(OP_TICK, 8'hFF, 1'b1);
    push_item(OP_TICK, 8'h00, 1'b0);
    run_read(RUN_OK, 8'd1, 8'hFF);
    run_read(RUN_BUSY, 8'd3, -1);
    run_read(RUN_START_ERR, 8'd3, -1);
    quiesce();
    set_registers(8'h00, 8'd2);
    run_read(RUN_NO_ACK, 8'd5, -1);
    run_read(RUN_OK, 8'd0, -1);
    run_read(RUN_OK, 8'd2, 8'h00);
    run_read(RUN_OK, 8'd6, -1);

    for (phase_no = 0; phase_no < 5; phase_no++) begin
      quiesce();
      case (phase_no)
        0: set_registers(8'hFF, 8'd0);
        1: set_registers(8'h5A, 8'd255);
        default: set_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 6)));
      endcase
      phase_end = items_sent + 100;
      while (items_sent < phase_end) begin
        choice = $urandom_range(0, 99);
        if (choice < 70) count = 8'($urandom_range(0, 2));
        else if (choice < 95) count = 8'($urandom_range(3, 6));
        else count = 8'($urandom_range(7, 16));
        choice = $urandom_range(0, 99);
        if (choice < 10) begin
          noise_burst();
          do push_item(OP_TICK, 8'($urandom_range(0, 255)), 1'b0); while (!seq_idle);
        end else if (choice < 18) begin
          run_read(RUN_BUSY, count, -1);
        end else if (choice < 26) begin
          run_read(RUN_START_ERR, count, -1);
        end else if (choice < 34) begin
          run_read(RUN_NO_ACK, count, -1);
        end else begin
          run_read(RUN_OK, count, -1);
        end
      end
    end

    quiesce();
    repeat (4) @(posedge clk);
    $display("%0d tick and begin transactions sent, %0d results checked, %0d bytes read",
             items_sent, results_seen, bytes_seen);
    $display("%0d reads finished cleanly, %0d ended busy, with start error or without ack",
             clean_ends, aborted_ends);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS i2c_master_read_sequencer");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, pending);
      $display("FAIL i2c_master_read_sequencer");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/i2cmrs_pkg.sv
hw/rtl/i2cmrs_core.sv
hw/rtl/i2cmrs_out_reg.sv
hw/rtl/i2c_master_read_sequencer.sv
tb/sv/i2c_master_read_sequencer_checker.sv
tb/sv/i2c_master_read_sequencer_test.sv
